@@ rtl/iwfe_pkg.sv @@
// Shared widths, types and mean helpers for the IMU window feature extractor.
package iwfe_pkg;

    // Sample and window sizing (window length must be a power of two)
    localparam int SAMPLE_W   = 16;
    localparam int WINDOW_LEN = 8;
    localparam int WIN_SHIFT  = $clog2(WINDOW_LEN);
    localparam int CNT_W      = (WIN_SHIFT < 1) ? 1 : WIN_SHIFT;

    // Derived datapath widths
    localparam int SQ_W       = 2 * SAMPLE_W;
    localparam int MAG_W      = SAMPLE_W;
    localparam int REM_W      = SAMPLE_W + 1;
    localparam int ROOT_STEPS = SAMPLE_W;
    localparam int STEP_W     = $clog2(ROOT_STEPS);
    localparam int SUM_W      = SAMPLE_W + WIN_SHIFT;
    localparam int MSUM_W     = MAG_W + WIN_SHIFT;
    localparam int MEAN_W     = 20;
    localparam int FRAC_W     = 4;
    localparam int SNUM_W     = SUM_W + FRAC_W;
    localparam int UNUM_W     = MSUM_W + FRAC_W;

    // Axis select for the shared squaring multiplier
    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic      load;
        logic      sq_en;
        axis_sel_t sq_sel;
        logic      root_step;
        logic      commit;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic result_pending;
    } status_t;

    // Signed window mean in Q.4, floored, saturated to the output width
    function automatic logic [MEAN_W-1:0] mean_signed(input logic signed [SUM_W-1:0] s);
        logic signed [SNUM_W-1:0] num;
        logic signed [SNUM_W-1:0] q;
        logic [MEAN_W-1:0]        res;
        num = SNUM_W'(s) <<< FRAC_W;
        q   = num >>> WIN_SHIFT;
        if ((&q[SNUM_W-1:MEAN_W-1]) || !(|q[SNUM_W-1:MEAN_W-1]))
        begin
            res = q[MEAN_W-1:0];
        end
        else if (q[SNUM_W-1])
        begin
            res = {1'b1, {(MEAN_W-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(MEAN_W-1){1'b1}}};
        end
        return res;
    endfunction

    // Unsigned window mean in Q.4, floored, saturated to the output width
    function automatic logic [MEAN_W-1:0] mean_unsigned(input logic [MSUM_W-1:0] s);
        logic [UNUM_W-1:0] num;
        logic [UNUM_W-1:0] q;
        logic [MEAN_W-1:0] res;
        num = {s, {FRAC_W{1'b0}}};
        q   = num >> WIN_SHIFT;
        if (|q[UNUM_W-1:MEAN_W])
        begin
            res = {MEAN_W{1'b1}};
        end
        else
        begin
            res = q[MEAN_W-1:0];
        end
        return res;
    endfunction

endpackage

@@ rtl/iwfe_ctrl.sv @@
// Sequencing state machine: accept, square, root iterations, commit.
module iwfe_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  iwfe_pkg::status_t status,
    output iwfe_pkg::cmd_t    cmd
);
    import iwfe_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SQUARE = 4'b0010,
        ST_ROOT   = 4'b0100,
        ST_COMMIT = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    axis_sel_t         axis_reg, axis_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_free;

    // Output register can take a new result when empty or being drained
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and command decode
    always_comb
    begin
        state_next    = state_reg;
        axis_next     = axis_reg;
        step_next     = step_reg;
        cmd.load      = 1'b0;
        cmd.sq_en     = 1'b0;
        cmd.sq_sel    = axis_reg;
        cmd.root_step = 1'b0;
        cmd.commit    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    axis_next  = AXIS_X;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                cmd.sq_en = 1'b1;
                case (axis_reg)
                    AXIS_X:  axis_next = AXIS_Y;
                    AXIS_Y:  axis_next = AXIS_Z;
                    default:
                    begin
                        axis_next  = AXIS_X;
                        step_next  = '0;
                        state_next = ST_ROOT;
                    end
                endcase
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                step_next     = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(ROOT_STEPS - 1))
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                // Hold while a pending result cannot enter the output register
                if (!status.result_pending || out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on a committed result, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.commit && status.result_pending)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= AXIS_X;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/iwfe_datapath.sv @@
// Datapath: sample capture, squaring, bit-pair square root, window and batch state.
module iwfe_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  iwfe_pkg::cmd_t                      cmd,
    output iwfe_pkg::status_t                   status,
    input  logic signed [iwfe_pkg::SAMPLE_W-1:0] theta,
    input  logic signed [iwfe_pkg::SAMPLE_W-1:0] phi,
    input  logic signed [iwfe_pkg::SAMPLE_W-1:0] accel_x,
    input  logic signed [iwfe_pkg::SAMPLE_W-1:0] accel_y,
    input  logic signed [iwfe_pkg::SAMPLE_W-1:0] accel_z,
    input  logic                                batch_end,
    output logic signed [iwfe_pkg::MEAN_W-1:0]  mean_theta,
    output logic signed [iwfe_pkg::MEAN_W-1:0]  mean_phi,
    output logic [iwfe_pkg::MEAN_W-1:0]         mean_magnitude,
    output logic                                window_valid,
    output logic [iwfe_pkg::MAG_W-1:0]          magnitude_range,
    output logic                                range_valid
);
    import iwfe_pkg::*;

    // Captured request
    logic signed [SAMPLE_W-1:0] theta_in_reg, phi_in_reg;
    logic signed [SAMPLE_W-1:0] ax_reg, ay_reg, az_reg;
    logic                       batch_end_reg;

    // Squaring and root
    logic signed [SAMPLE_W-1:0] sq_operand;
    logic signed [SQ_W-1:0]     sq_product;
    logic [SQ_W-1:0]            rad_reg;
    logic [REM_W-1:0]           rem_reg;
    logic [MAG_W-1:0]           root_reg;
    logic [REM_W+1:0]           rem_trial;
    logic [REM_W+1:0]           root_trial;
    logic                       root_fits;

    // Window and batch state
    logic signed [SUM_W-1:0]    theta_sum_reg, phi_sum_reg;
    logic [MSUM_W-1:0]          mag_sum_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [MAG_W-1:0]           min_reg, max_reg;
    logic signed [SUM_W-1:0]    theta_sum_next, phi_sum_next;
    logic [MSUM_W-1:0]          mag_sum_next;
    logic [MAG_W-1:0]           min_next, max_next;
    logic                       win_done;

    // Result register
    logic [MEAN_W-1:0]          mean_theta_reg, mean_phi_reg, mean_mag_reg;
    logic                       window_valid_reg, range_valid_reg;
    logic [MAG_W-1:0]           range_reg;

    // Select the axis for the shared multiplier
    always_comb
    begin
        case (cmd.sq_sel)
            AXIS_X:  sq_operand = ax_reg;
            AXIS_Y:  sq_operand = ay_reg;
            AXIS_Z:  sq_operand = az_reg;
            default: sq_operand = '0;
        endcase
    end

    assign sq_product = sq_operand * sq_operand;

    // One result bit per step: bring down two radicand bits, try root*4+1
    assign rem_trial  = {rem_reg, rad_reg[SQ_W-1 -: 2]};
    assign root_trial = (REM_W + 2)'({root_reg, 2'b01});
    assign root_fits  = (rem_trial >= root_trial);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            theta_in_reg  <= theta;
            phi_in_reg    <= phi;
            ax_reg        <= accel_x;
            ay_reg        <= accel_y;
            az_reg        <= accel_z;
            batch_end_reg <= batch_end;
            rad_reg       <= '0;
            rem_reg       <= '0;
            root_reg      <= '0;
        end
        else if (cmd.sq_en)
        begin
            rad_reg <= rad_reg + SQ_W'(unsigned'(sq_product));
        end
        else if (cmd.root_step)
        begin
            rad_reg  <= {rad_reg[SQ_W-3:0], 2'b00};
            if (root_fits)
            begin
                rem_reg  <= REM_W'(rem_trial - root_trial);
                root_reg <= {root_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= REM_W'(rem_trial);
                root_reg <= {root_reg[MAG_W-2:0], 1'b0};
            end
        end
    end

    // Fold the current sample into the window and batch figures
    assign theta_sum_next = theta_sum_reg + SUM_W'(theta_in_reg);
    assign phi_sum_next   = phi_sum_reg + SUM_W'(phi_in_reg);
    assign mag_sum_next   = mag_sum_reg + MSUM_W'(root_reg);
    assign max_next       = (root_reg > max_reg) ? root_reg : max_reg;
    assign min_next       = (root_reg < min_reg) ? root_reg : min_reg;
    assign win_done       = (count_reg == CNT_W'(WINDOW_LEN - 1));

    assign status.result_pending = win_done || batch_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            theta_sum_reg <= '0;
            phi_sum_reg   <= '0;
            mag_sum_reg   <= '0;
            count_reg     <= '0;
            min_reg       <= '1;
            max_reg       <= '0;
        end
        else if (cmd.commit)
        begin
            // Clear the window on completion or at batch end (drops a partial window)
            if (win_done || batch_end_reg)
            begin
                theta_sum_reg <= '0;
                phi_sum_reg   <= '0;
                mag_sum_reg   <= '0;
                count_reg     <= '0;
            end
            else
            begin
                theta_sum_reg <= theta_sum_next;
                phi_sum_reg   <= phi_sum_next;
                mag_sum_reg   <= mag_sum_next;
                count_reg     <= count_reg + CNT_W'(1);
            end
            // Restart the range tracking after the batch's last sample
            if (batch_end_reg)
            begin
                min_reg <= '1;
                max_reg <= '0;
            end
            else
            begin
                min_reg <= min_next;
                max_reg <= max_next;
            end
        end
    end

    // Load the result register with the request's result
    always_ff @(posedge clk)
    begin
        if (cmd.commit && status.result_pending)
        begin
            window_valid_reg <= win_done;
            range_valid_reg  <= batch_end_reg;
            mean_theta_reg   <= win_done ? mean_signed(theta_sum_next) : '0;
            mean_phi_reg     <= win_done ? mean_signed(phi_sum_next) : '0;
            mean_mag_reg     <= win_done ? mean_unsigned(mag_sum_next) : '0;
            range_reg        <= batch_end_reg ? (max_next - min_next) : '0;
        end
    end

    assign mean_theta      = signed'(mean_theta_reg);
    assign mean_phi        = signed'(mean_phi_reg);
    assign mean_magnitude  = mean_mag_reg;
    assign window_valid    = window_valid_reg;
    assign magnitude_range = range_reg;
    assign range_valid     = range_valid_reg;

endmodule

@@ rtl/imu_window_feature_extractor_unit.sv @@
// Top level of the IMU window feature extractor: controller plus datapath.
// Each accepted request runs through these steps before the next one is taken: capture
// the sample, sum the squared acceleration axes on one shared 16x16 multiplier, run the
// bit-pair square root (one magnitude bit per cycle), and update the window sums and the
// batch minimum and maximum. in_stall stays high through that sequence. A result (window
// means, batch range, or both) sits in an output register, so the next sample is taken
// while it waits; the commit step holds only if a new result is due and the previous one
// is still stalled. Means are floored Q.4 over windows of 8 samples; a partial window at
// batch end is dropped.
module imu_window_feature_extractor_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [iwfe_pkg::SAMPLE_W-1:0] theta,
    input  logic signed [iwfe_pkg::SAMPLE_W-1:0] phi,
    input  logic signed [iwfe_pkg::SAMPLE_W-1:0] accel_x,
    input  logic signed [iwfe_pkg::SAMPLE_W-1:0] accel_y,
    input  logic signed [iwfe_pkg::SAMPLE_W-1:0] accel_z,
    input  logic                                batch_end,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [iwfe_pkg::MEAN_W-1:0]  mean_theta,
    output logic signed [iwfe_pkg::MEAN_W-1:0]  mean_phi,
    output logic [iwfe_pkg::MEAN_W-1:0]         mean_magnitude,
    output logic                                window_valid,
    output logic [iwfe_pkg::MAG_W-1:0]          magnitude_range,
    output logic                                range_valid
);
    import iwfe_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequencer
    iwfe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Arithmetic and state
    iwfe_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .theta           (theta),
        .phi             (phi),
        .accel_x         (accel_x),
        .accel_y         (accel_y),
        .accel_z         (accel_z),
        .batch_end       (batch_end),
        .mean_theta      (mean_theta),
        .mean_phi        (mean_phi),
        .mean_magnitude  (mean_magnitude),
        .window_valid    (window_valid),
        .magnitude_range (magnitude_range),
        .range_valid     (range_valid)
    );

endmodule

@@ rtl/iwfe_checker.sv @@
// Port-level assertions for the IMU window feature extractor, bound to the top level.
module iwfe_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic signed [iwfe_pkg::MEAN_W-1:0]  mean_theta,
    input logic signed [iwfe_pkg::MEAN_W-1:0]  mean_phi,
    input logic [iwfe_pkg::MEAN_W-1:0]         mean_magnitude,
    input logic                                window_valid,
    input logic [iwfe_pkg::MAG_W-1:0]          magnitude_range,
    input logic                                range_valid
);
    import iwfe_pkg::*;

    // Block busy right after taking a request
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after accepting a request");

    // A result always carries a window or a range
    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (window_valid || range_valid))
        else $error("result with neither window nor range");

    // Fields without their valid flag read zero
    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((window_valid || (mean_theta == '0 && mean_phi == '0
            && mean_magnitude == '0)) && (range_valid || magnitude_range == '0)))
        else $error("unflagged result field not zero");

    // A new result appears only at the end of a busy sequence
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a request in progress");

    // A stalled result is held
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result dropped while stalled");

endmodule

bind imu_window_feature_extractor_unit iwfe_checker u_iwfe_checker (.*);
